[src/lcd4_pkg.sv]
// Shared types and constants for the 4-bit character LCD write sequencer.
// Holds the request and result payload structs, configuration struct and init table.
// No dependencies.
`default_nettype none

package lcd4_pkg;

    // Request kinds
    localparam logic [1:0] KIND_TICK = 2'd0;
    localparam logic [1:0] KIND_CMD  = 2'd1;
    localparam logic [1:0] KIND_DATA = 2'd2;

    // Register map: index = paddr[3:2]
    localparam int unsigned ADDR_W = 4;
    localparam logic [1:0] REG_PULSE = 2'd0;
    localparam logic [1:0] REG_HOLD  = 2'd1;
    localparam logic [1:0] REG_PWRUP = 2'd2;

    // Register reset values
    localparam logic [7:0]  PULSE_RESET = 8'd2;
    localparam logic [7:0]  HOLD_RESET  = 8'd2;
    localparam logic [15:0] PWRUP_RESET = 16'd110;

    // Init sequence
    localparam logic [3:0]  INIT_NIBBLES   = 4'd8;
    localparam logic [3:0]  INIT_CLEAR     = 4'd8;
    localparam logic [3:0]  INIT_DONE      = 4'd9;
    localparam logic [7:0]  CLEAR_BYTE     = 8'h01;
    localparam logic [15:0] WAIT_FIRST     = 16'd3;
    localparam logic [15:0] WAIT_OTHER     = 16'd2;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] byte_value;
    } req_t;

    typedef struct packed {
        logic       pin_rs;
        logic       pin_e;
        logic [3:0] data_nibble;
        logic       busy_res;
        logic       rejected;
    } res_t;

    // Register contents plus a strobe for a power-up register write
    typedef struct packed {
        logic [7:0]  pulse_ticks;
        logic [7:0]  hold_ticks;
        logic [15:0] power_up_ticks;
        logic        pwrup_load;
    } cfg_t;

    // Nibbles of the 4-bit init sequence: 3,3,3,2,2,8,0,C
    function automatic logic [3:0] init_nibble(input logic [2:0] step);
        logic [3:0] nib;
        case (step)
            3'd0:    nib = 4'h3;
            3'd1:    nib = 4'h3;
            3'd2:    nib = 4'h3;
            3'd3:    nib = 4'h2;
            3'd4:    nib = 4'h2;
            3'd5:    nib = 4'h8;
            3'd6:    nib = 4'h0;
            default: nib = 4'hC;
        endcase
        return nib;
    endfunction

endpackage

`default_nettype wire

[src/lcd4_regs.sv]
// APB-style configuration registers for the LCD write sequencer.
// Depends on lcd4_pkg for the register map and cfg_t.
`default_nettype none

module lcd4_regs (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [lcd4_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]                pwdata,
    output logic      [31:0]                prdata,
    output logic                            pready,
    output lcd4_pkg::cfg_t                  cfg
);

    logic [7:0]  pulse_reg;
    logic [7:0]  hold_reg;
    logic [15:0] pwrup_reg;
    logic        wr_en;
    logic [1:0]  reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[3:2];

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pulse_reg <= lcd4_pkg::PULSE_RESET;
            hold_reg  <= lcd4_pkg::HOLD_RESET;
            pwrup_reg <= lcd4_pkg::PWRUP_RESET;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                lcd4_pkg::REG_PULSE: pulse_reg <= pwdata[7:0];
                lcd4_pkg::REG_HOLD:  hold_reg  <= pwdata[7:0];
                lcd4_pkg::REG_PWRUP: pwrup_reg <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // Read mux
    always_comb
    begin
        case (reg_idx)
            lcd4_pkg::REG_PULSE: prdata = {24'd0, pulse_reg};
            lcd4_pkg::REG_HOLD:  prdata = {24'd0, hold_reg};
            lcd4_pkg::REG_PWRUP: prdata = {16'd0, pwrup_reg};
            default:             prdata = 32'd0;
        endcase
    end

    // Power-up write strobe carries the new value straight through
    always_comb
    begin
        cfg.pulse_ticks    = pulse_reg;
        cfg.hold_ticks     = hold_reg;
        cfg.power_up_ticks = (wr_en && reg_idx == lcd4_pkg::REG_PWRUP) ?
                             pwdata[15:0] : pwrup_reg;
        cfg.pwrup_load     = wr_en && (reg_idx == lcd4_pkg::REG_PWRUP);
    end

endmodule

`default_nettype wire

[src/lcd4_seq.sv]
// Sequencer core: request register, phase/timer update logic, result register.
// Depends on lcd4_pkg for payload types, cfg_t and the init nibble table.
`default_nettype none

module lcd4_seq (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           req_valid,
    output logic                req_stall,
    input  wire lcd4_pkg::req_t req_data,
    output logic                res_valid,
    input  wire logic           res_stall,
    output lcd4_pkg::res_t      res_data,
    input  wire lcd4_pkg::cfg_t cfg
);

    typedef enum logic [2:0] {
        PH_IDLE       = 3'd0,
        PH_INIT_WAIT  = 3'd1,
        PH_INIT_PULSE = 3'd2,
        PH_INIT_HOLD  = 3'd3,
        PH_HI_PULSE   = 3'd4,
        PH_HI_HOLD    = 3'd5,
        PH_LO_PULSE   = 3'd6,
        PH_LO_HOLD    = 3'd7
    } phase_t;

    phase_t          phase_reg,   phase_next;
    logic [3:0]      step_reg,    step_next;
    logic [15:0]     delay_reg,   delay_next;
    logic [7:0]      pend_reg,    pend_next;
    logic            rs_reg,      rs_next;
    logic            e_reg,       e_next;
    logic [3:0]      nib_reg,     nib_next;
    logic            in_full_reg, in_full_next;
    lcd4_pkg::req_t  in_reg;
    logic            out_full_reg, out_full_next;
    lcd4_pkg::res_t  out_reg,     out_next;
    logic            proc;
    logic            rej;
    logic [15:0]     dec;
    logic [3:0]      step_inc;

    // Handshake: process the held request whenever the result register can take it
    assign proc      = in_full_reg & (~out_full_reg | ~res_stall);
    assign req_stall = in_full_reg & ~proc;
    assign res_valid = out_full_reg;
    assign res_data  = out_reg;
    assign dec       = (delay_reg != 16'd0) ? delay_reg - 16'd1 : 16'd0;
    assign step_inc  = step_reg + 4'd1;

    always_comb
    begin
        in_full_next  = (req_valid & ~req_stall) ? 1'b1 : (proc ? 1'b0 : in_full_reg);
        out_full_next = proc ? 1'b1 : ((out_full_reg & ~res_stall) ? 1'b0 : out_full_reg);
    end

    // Phase and pin update for one request
    always_comb
    begin
        phase_next = phase_reg;
        step_next  = step_reg;
        delay_next = delay_reg;
        pend_next  = pend_reg;
        rs_next    = rs_reg;
        e_next     = e_reg;
        nib_next   = nib_reg;
        rej        = 1'b0;

        if (proc)
        begin
            case (in_reg.kind)
                lcd4_pkg::KIND_TICK:
                begin
                    if (phase_reg != PH_IDLE)
                    begin
                        delay_next = dec;
                        if (dec == 16'd0)
                        begin
                            case (phase_reg)
                                PH_INIT_WAIT:
                                begin
                                    rs_next    = 1'b0;
                                    e_next     = 1'b1;
                                    delay_next = {8'd0, cfg.pulse_ticks};
                                    if (step_reg < lcd4_pkg::INIT_NIBBLES)
                                    begin
                                        nib_next   = lcd4_pkg::init_nibble(step_reg[2:0]);
                                        phase_next = PH_INIT_PULSE;
                                    end
                                    else
                                    begin
                                        pend_next  = lcd4_pkg::CLEAR_BYTE;
                                        nib_next   = lcd4_pkg::CLEAR_BYTE[7:4];
                                        phase_next = PH_HI_PULSE;
                                    end
                                end
                                PH_INIT_PULSE:
                                begin
                                    e_next     = 1'b0;
                                    delay_next = {8'd0, cfg.hold_ticks};
                                    phase_next = PH_INIT_HOLD;
                                end
                                PH_INIT_HOLD:
                                begin
                                    step_next  = step_inc;
                                    delay_next = (step_inc == 4'd1) ?
                                                 lcd4_pkg::WAIT_FIRST : lcd4_pkg::WAIT_OTHER;
                                    phase_next = PH_INIT_WAIT;
                                end
                                PH_HI_PULSE:
                                begin
                                    e_next     = 1'b0;
                                    delay_next = {8'd0, cfg.hold_ticks};
                                    phase_next = PH_HI_HOLD;
                                end
                                PH_HI_HOLD:
                                begin
                                    nib_next   = pend_reg[3:0];
                                    e_next     = 1'b1;
                                    delay_next = {8'd0, cfg.pulse_ticks};
                                    phase_next = PH_LO_PULSE;
                                end
                                PH_LO_PULSE:
                                begin
                                    e_next     = 1'b0;
                                    delay_next = {8'd0, cfg.hold_ticks};
                                    phase_next = PH_LO_HOLD;
                                end
                                PH_LO_HOLD:
                                begin
                                    if (step_reg == lcd4_pkg::INIT_CLEAR)
                                        step_next = lcd4_pkg::INIT_DONE;
                                    phase_next = PH_IDLE;
                                end
                                default: ;
                            endcase
                        end
                    end
                end
                lcd4_pkg::KIND_CMD, lcd4_pkg::KIND_DATA:
                begin
                    if (phase_reg != PH_IDLE)
                        rej = 1'b1;
                    else
                    begin
                        pend_next  = in_reg.byte_value;
                        rs_next    = (in_reg.kind == lcd4_pkg::KIND_DATA);
                        nib_next   = in_reg.byte_value[7:4];
                        e_next     = 1'b1;
                        delay_next = {8'd0, cfg.pulse_ticks};
                        phase_next = PH_HI_PULSE;
                    end
                end
                default: ;
            endcase
        end
        else if (cfg.pwrup_load && phase_reg == PH_INIT_WAIT && step_reg == 4'd0)
        begin
            // power-up wait restarts with the new value
            delay_next = cfg.power_up_ticks;
        end

        out_next.pin_rs      = rs_next;
        out_next.pin_e       = e_next;
        out_next.data_nibble = nib_next;
        out_next.busy_res    = (phase_next != PH_IDLE);
        out_next.rejected    = rej;
    end

    // State, request register and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_INIT_WAIT;
            step_reg     <= 4'd0;
            delay_reg    <= lcd4_pkg::PWRUP_RESET;
            pend_reg     <= 8'd0;
            rs_reg       <= 1'b0;
            e_reg        <= 1'b0;
            nib_reg      <= 4'd0;
            in_full_reg  <= 1'b0;
            out_full_reg <= 1'b0;
        end
        else
        begin
            phase_reg    <= phase_next;
            step_reg     <= step_next;
            delay_reg    <= delay_next;
            pend_reg     <= pend_next;
            rs_reg       <= rs_next;
            e_reg        <= e_next;
            nib_reg      <= nib_next;
            in_full_reg  <= in_full_next;
            out_full_reg <= out_full_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (req_valid && !req_stall)
            in_reg <= req_data;
        if (proc)
            out_reg <= out_next;
    end

endmodule

`default_nettype wire

[src/char_lcd_4bit_write_sequencer.sv]
// Top level of the 4-bit character LCD write sequencer.
// Depends on lcd4_pkg, lcd4_regs and lcd4_seq.
//
//   channel   signals                          payload
//   request   req_valid / req_stall / req_data lcd4_pkg::req_t (kind, byte_value)
//   result    res_valid / res_stall / res_data lcd4_pkg::res_t (pins, busy, rejected)
//   config    psel/penable/pwrite/paddr/...    pulse, hold, power-up tick counts
//
// Each request gives one result via the request register, then the result register.
// One request a cycle is sustained while res_stall is low, set by those single registers.
// After reset the block runs the power-up init on timer ticks; writes are rejected until
// it is done. A stalled result holds the result register; the request register then
// fills and req_stall rises.
`default_nettype none

module char_lcd_4bit_write_sequencer (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        req_valid,
    output logic                             req_stall,
    input  wire lcd4_pkg::req_t              req_data,
    output logic                             res_valid,
    input  wire logic                        res_stall,
    output lcd4_pkg::res_t                   res_data,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [lcd4_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]                 pwdata,
    output logic      [31:0]                 prdata,
    output logic                             pready
);

    lcd4_pkg::cfg_t cfg;

    lcd4_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    lcd4_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data),
        .cfg       (cfg)
    );

endmodule

`default_nettype wire
